FILE: design/svsm_pkg.sv
// Package for the supply voltage stability monitor.
// Holds the sequencer states, register indexes, reset values and shared structs.
// No dependencies; the other design files that use it refer to it by scoped names.
package svsm_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN_MV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX_MV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_LIMIT_MV = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_RUN   = 3'd5;

  // Register values after reset.
  localparam logic [7:0]  RST_SAMPLE_COUNT   = 8'd8;
  localparam logic [23:0] RST_GAIN_Q16       = 24'd580921;
  localparam logic [15:0] RST_WINDOW_MIN_MV  = 16'd9000;
  localparam logic [15:0] RST_WINDOW_MAX_MV  = 16'd16000;
  localparam logic [15:0] RST_DELTA_LIMIT_MV = 16'd500;
  localparam logic [15:0] RST_REQUIRED_RUN   = 16'd10;

  // A run of this many small changes marks the supply as stable.
  localparam logic [15:0] STABLE_THRESHOLD = 16'd5;
  localparam logic [15:0] MV_MAX           = 16'hFFFF;

  // Binary point of the gain.
  localparam int GAIN_FRAC = 16;

  // Configuration register file contents.
  typedef struct packed {
    logic [7:0]  sample_count;
    logic [23:0] gain_q16;
    logic [15:0] window_min_mv;
    logic [15:0] window_max_mv;
    logic [15:0] delta_limit_mv;
    logic [15:0] required_run;
  } cfg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_MUL,
    S_SAT,
    S_DIFF,
    S_NEG,
    S_LIM,
    S_WLO,
    S_WHI,
    S_RUN,
    S_RDY
  } state_t;

  // Status the sequencer reports to the top level.
  typedef struct packed {
    state_t state;
  } status_t;

endpackage

FILE: design/svsm_in_if.sv
// Input channel carrying one raw ADC sample per item.
// Depends on nothing; the sample width follows ADC_BITS.
interface svsm_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

FILE: design/svsm_out_if.sv
// Result channel carrying one measurement verdict per item.
// Depends on nothing.
interface svsm_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] average_raw;
  logic [15:0] supply_mv;
  logic        in_range;
  logic        supply_steady;
  logic        upgrade_ok;
  logic        upgrade_ready;
  logic [15:0] stable_run;

  modport source (output valid, output average_raw, output supply_mv, output in_range,
                  output supply_steady, output upgrade_ok, output upgrade_ready,
                  output stable_run, input ready);
  modport sink   (input valid, input average_raw, input supply_mv, input in_range,
                  input supply_steady, input upgrade_ok, input upgrade_ready,
                  input stable_run, output ready);
endinterface

FILE: design/svsm_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on svsm_pkg for the port geometry.
interface svsm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [svsm_pkg::CFG_IDX_W-1:0]   index;
  logic [svsm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/svsm_cfg_regs.sv
// Configuration register file of the stability monitor.
// Depends on svsm_pkg and svsm_cfg_if.
module svsm_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  svsm_cfg_if.sink           cfg_ch,
  output svsm_pkg::cfg_t     cfg
);

  // Writes are always taken; an index past the last register is dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_count   <= svsm_pkg::RST_SAMPLE_COUNT;
      cfg.gain_q16       <= svsm_pkg::RST_GAIN_Q16;
      cfg.window_min_mv  <= svsm_pkg::RST_WINDOW_MIN_MV;
      cfg.window_max_mv  <= svsm_pkg::RST_WINDOW_MAX_MV;
      cfg.delta_limit_mv <= svsm_pkg::RST_DELTA_LIMIT_MV;
      cfg.required_run   <= svsm_pkg::RST_REQUIRED_RUN;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        svsm_pkg::REG_SAMPLE_COUNT:   cfg.sample_count   <= cfg_ch.data[7:0];
        svsm_pkg::REG_GAIN_Q16:       cfg.gain_q16       <= cfg_ch.data[23:0];
        svsm_pkg::REG_WINDOW_MIN_MV:  cfg.window_min_mv  <= cfg_ch.data[15:0];
        svsm_pkg::REG_WINDOW_MAX_MV:  cfg.window_max_mv  <= cfg_ch.data[15:0];
        svsm_pkg::REG_DELTA_LIMIT_MV: cfg.delta_limit_mv <= cfg_ch.data[15:0];
        svsm_pkg::REG_REQUIRED_RUN:   cfg.required_run   <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/svsm_alu.sv
// Shared adder/subtractor of the stability monitor.
// Depends on nothing; width set by the instantiating module.
module svsm_alu #(
  parameter int W = 44
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         borrow
);

  logic [W:0] full;

  // Subtraction adds the two's complement; a missing carry out means a < b.
  always_comb begin
    full   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
    res    = full[W-1:0];
    borrow = sub & ~full[W];
  end

endmodule

FILE: design/svsm_ctrl.sv
// Sequencer and datapath registers of the stability monitor.
// Depends on svsm_pkg, the channel interfaces and svsm_alu.
module svsm_ctrl #(
  parameter int ADC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  svsm_pkg::cfg_t       cfg,
  svsm_in_if.sink              in_ch,
  svsm_out_if.source           out_ch,
  output svsm_pkg::status_t    status
);

  // Up to 255 samples may be summed before a measurement completes.
  localparam int SUM_W  = ADC_BITS + 8;
  localparam int PROD_W = SUM_W + 24;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SUM_W - 1);

  svsm_pkg::state_t state, state_next;

  logic [ADC_BITS-1:0] sample;
  logic [SUM_W-1:0]    sum;
  logic [7:0]          sample_index;
  logic [7:0]          rem;
  logic [CNT_W-1:0]    bit_cnt;
  logic [PROD_W-1:0]   prod;
  logic [11:0]         avg;
  logic [15:0]         mv;
  logic [15:0]         diff;
  logic                small_change;
  logic                ge_min;
  logic                le_max;
  logic [15:0]         reference_mv;
  logic [15:0]         run_count;
  logic [15:0]         latched_run;
  logic                stable;

  logic [PROD_W-1:0] alu_a, alu_b, alu_res;
  logic              alu_sub, alu_borrow;

  logic [7:0]  count_eff;
  logic [7:0]  idx_inc;
  logic        meas_done;
  logic [8:0]  trial;
  logic [15:0] run_inc;
  logic        run_stable;
  logic        slot_free;
  logic        in_fire;
  logic        out_load;

  svsm_alu #(.W(PROD_W)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // Helper values for the accumulate, divide and run-count steps.
  always_comb begin
    count_eff  = (cfg.sample_count == 8'd0) ? 8'd1 : cfg.sample_count;
    idx_inc    = sample_index + 8'd1;
    meas_done  = (idx_inc == 8'd0) || (idx_inc >= count_eff);
    trial      = {rem, sum[SUM_W-1]};
    run_inc    = (run_count == svsm_pkg::MV_MAX) ? run_count : run_count + 16'd1;
    run_stable = small_change && (run_inc >= svsm_pkg::STABLE_THRESHOLD);
    slot_free  = !out_ch.valid || out_ch.ready;
    in_fire    = in_ch.valid && in_ch.ready;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svsm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, shared adder operands and handshake outputs.
  always_comb begin
    state_next  = state;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b1;
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      svsm_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = svsm_pkg::S_ACC;
        end
      end
      svsm_pkg::S_ACC: begin
        alu_a      = PROD_W'(sum);
        alu_b      = PROD_W'(sample);
        alu_sub    = 1'b0;
        state_next = meas_done ? svsm_pkg::S_DIV : svsm_pkg::S_IDLE;
      end
      svsm_pkg::S_DIV: begin
        alu_a = PROD_W'(trial);
        alu_b = PROD_W'(count_eff);
        if (bit_cnt == LAST_BIT) begin
          state_next = svsm_pkg::S_MUL;
        end
      end
      svsm_pkg::S_MUL: begin
        alu_a   = {prod[PROD_W-2:0], 1'b0};
        alu_b   = sum[SUM_W-1] ? PROD_W'(cfg.gain_q16) : '0;
        alu_sub = 1'b0;
        if (bit_cnt == LAST_BIT) begin
          state_next = svsm_pkg::S_SAT;
        end
      end
      svsm_pkg::S_SAT: begin
        state_next = svsm_pkg::S_DIFF;
      end
      svsm_pkg::S_DIFF: begin
        alu_a      = PROD_W'(mv);
        alu_b      = PROD_W'(reference_mv);
        state_next = alu_borrow ? svsm_pkg::S_NEG : svsm_pkg::S_LIM;
      end
      svsm_pkg::S_NEG: begin
        alu_a      = PROD_W'(reference_mv);
        alu_b      = PROD_W'(mv);
        state_next = svsm_pkg::S_LIM;
      end
      svsm_pkg::S_LIM: begin
        alu_a      = PROD_W'(diff);
        alu_b      = PROD_W'(cfg.delta_limit_mv);
        state_next = svsm_pkg::S_WLO;
      end
      svsm_pkg::S_WLO: begin
        alu_a      = PROD_W'(mv);
        alu_b      = PROD_W'(cfg.window_min_mv);
        state_next = svsm_pkg::S_WHI;
      end
      svsm_pkg::S_WHI: begin
        alu_a      = PROD_W'(cfg.window_max_mv);
        alu_b      = PROD_W'(mv);
        state_next = svsm_pkg::S_RUN;
      end
      svsm_pkg::S_RUN: begin
        state_next = svsm_pkg::S_RDY;
      end
      svsm_pkg::S_RDY: begin
        alu_a = PROD_W'(latched_run);
        alu_b = PROD_W'(cfg.required_run);
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = svsm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = svsm_pkg::S_IDLE;
      end
    endcase
  end

  // Measurement state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      sample_index <= '0;
      reference_mv <= '0;
      run_count    <= '0;
      latched_run  <= '0;
    end else begin
      unique case (state)
        svsm_pkg::S_ACC: begin
          sum          <= alu_res[SUM_W-1:0];
          sample_index <= meas_done ? 8'd0 : idx_inc;
        end
        // Restoring division: quotient bits shift in from the right.
        svsm_pkg::S_DIV: begin
          sum <= {sum[SUM_W-2:0], ~alu_borrow};
        end
        // Multiplier bits leave at the top, so the sum ends up cleared.
        svsm_pkg::S_MUL: begin
          sum <= {sum[SUM_W-2:0], 1'b0};
        end
        svsm_pkg::S_RUN: begin
          run_count <= small_change ? run_inc : 16'd0;
          if (run_stable) begin
            latched_run <= run_inc;
          end else begin
            reference_mv <= mv;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of one measurement.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample <= in_ch.adc_sample;
    end
    unique case (state)
      svsm_pkg::S_ACC: begin
        rem     <= '0;
        bit_cnt <= '0;
      end
      svsm_pkg::S_DIV: begin
        rem     <= alu_borrow ? trial[7:0] : alu_res[7:0];
        bit_cnt <= (bit_cnt == LAST_BIT) ? '0 : bit_cnt + CNT_W'(1);
        prod    <= '0;
      end
      svsm_pkg::S_MUL: begin
        if (bit_cnt == '0) begin
          avg <= 12'(sum);
        end
        prod    <= alu_res;
        bit_cnt <= bit_cnt + CNT_W'(1);
      end
      // Drop the fraction and clamp to the 16-bit millivolt range.
      svsm_pkg::S_SAT: begin
        mv <= (|prod[PROD_W-1:svsm_pkg::GAIN_FRAC+16]) ? svsm_pkg::MV_MAX
                                                       : prod[svsm_pkg::GAIN_FRAC +: 16];
      end
      svsm_pkg::S_DIFF: begin
        diff <= alu_res[15:0];
      end
      svsm_pkg::S_NEG: begin
        diff <= alu_res[15:0];
      end
      svsm_pkg::S_LIM: begin
        small_change <= alu_borrow;
      end
      svsm_pkg::S_WLO: begin
        ge_min <= ~alu_borrow;
      end
      svsm_pkg::S_WHI: begin
        le_max <= ~alu_borrow;
      end
      svsm_pkg::S_RUN: begin
        stable <= run_stable;
      end
      default: ;
    endcase
  end

  // Output register: holds one finished item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.average_raw   <= avg;
      out_ch.supply_mv     <= mv;
      out_ch.in_range      <= ge_min & le_max;
      out_ch.supply_steady <= stable;
      out_ch.upgrade_ok    <= ge_min & le_max & stable;
      out_ch.upgrade_ready <= ge_min & le_max & stable & ~alu_borrow;
      out_ch.stable_run    <= latched_run;
    end
  end

  assign status.state = state;

endmodule

FILE: design/supply_voltage_stability_monitor.sv
// Top level of the supply voltage stability monitor.
// Depends on svsm_pkg, the channel interfaces, svsm_cfg_regs, svsm_alu and svsm_ctrl.
//
// Each item is one raw ADC sample. Samples are summed until sample_count of them
// have arrived (a count of zero acts as one); then the block emits one result: the
// truncated mean, that mean scaled to millivolts by the Q16 gain and clamped at
// 65535, a window check, and a stability verdict. A change from the reference
// voltage below delta_limit_mv extends a run; five in a row mark the supply stable,
// freeze the reference and latch the run. A sample that does not complete a
// measurement is only added to the sum. For a completing sample, one shared adder
// first divides the sum bit-serially, then forms the gain product by shift-and-add,
// then performs the compares one per cycle, and then waits for the result slot if
// it is occupied. The input is not ready during that time. A finished result
// sits in an output register, so the next sample is accepted while it waits.
// Configuration writes are taken at any cycle but belong to idle periods; they
// clear no state.
module supply_voltage_stability_monitor #(
  parameter int ADC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  svsm_in_if.sink     in_ch,
  svsm_out_if.source  out_ch,
  svsm_cfg_if.sink    cfg_ch
);

  svsm_pkg::cfg_t    cfg;
  svsm_pkg::status_t status;

  // Configuration registers.
  svsm_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Sequencer with the shared adder.
  svsm_ctrl #(.ADC_BITS(ADC_BITS)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .status (status)
  );

  // An accepted item is accumulated in the following cycle.
  a_accept_acc : assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (status.state == svsm_pkg::S_ACC))
    else $error("accepted item not accumulated");

  // The verdict bits of a result agree with each other.
  a_verdict : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((out_ch.upgrade_ok == (out_ch.in_range && out_ch.supply_steady))
                      && (!out_ch.upgrade_ready || out_ch.upgrade_ok)))
    else $error("inconsistent verdict bits");

  // A stable verdict always carries a latched run of at least the threshold.
  a_stable_run : assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.supply_steady) |-> (out_ch.stable_run >= svsm_pkg::STABLE_THRESHOLD))
    else $error("stable verdict with short run");

  // A new result is only loaded at the end of the sequence.
  a_load_point : assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> ($past(status.state) == svsm_pkg::S_RDY))
    else $error("result loaded outside the final step");

endmodule
